FILE: rtl/ipv4fd_pkg.sv
// Shared types, constants and helper functions for the IPv4 forwarding decision block.
// It has no dependencies. The route cell, the top level and the checker import it.
`timescale 1ns / 1ps

package ipv4fd_pkg;

  // Widths of the stream payloads. Each is padded up to whole bytes.
  localparam int S_TDATA_W = 112;
  localparam int M_TDATA_W = 64;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  // Header framing constants.
  localparam int HDR_WORDS = 10;
  localparam int ETH_HEADER_BYTES = 14;
  localparam int ICMP_HEADER_BYTES = 4;
  localparam int IPV4_HDR_BYTES = 20;
  localparam logic [15:0] MIN_FRAME_LEN = 16'(ETH_HEADER_BYTES + IPV4_HDR_BYTES);
  localparam logic [15:0] MIN_ICMP_FRAME_LEN =
      16'(ETH_HEADER_BYTES + IPV4_HDR_BYTES + ICMP_HEADER_BYTES);

  localparam logic [3:0] IP_VERSION_4 = 4'd4;
  localparam logic [3:0] IP_IHL_5 = 4'd5;
  localparam logic [7:0] PROTO_ICMP = 8'h01;
  localparam logic [7:0] ICMP_ECHO_REQUEST = 8'h08;
  localparam logic [15:0] TTL_ONE = 16'h0100;

  // Kind of an input transaction, carried on tuser.
  localparam logic OP_ROUTE_WRITE = 1'b0;
  localparam logic OP_HEADER_WORD = 1'b1;

  // Verdict codes.
  typedef enum logic [2:0] {
    ACT_MALFORMED    = 3'd0,
    ACT_BAD_CSUM     = 3'd1,
    ACT_PORT_UNREACH = 3'd2,
    ACT_ECHO_REPLY   = 3'd3,
    ACT_LOCAL_DROP   = 3'd4,
    ACT_TTL_EXCEEDED = 3'd5,
    ACT_NET_UNREACH  = 3'd6,
    ACT_FORWARD      = 3'd7
  } action_e;

  // Route entry write, broadcast to every cell of the route chain.
  typedef struct packed {
    logic        en;
    logic [3:0]  index;
    logic [31:0] dest;
    logic [31:0] mask;
    logic [1:0]  port;
    logic        valid;
  } route_wr_t;

  // Lookup token handed from one route cell to the next.
  typedef struct packed {
    logic        tok;
    logic [31:0] dst;
    logic        found;
    logic [5:0]  plen;
    logic [1:0]  port;
  } walk_t;

  // Ones-complement addition of two 16-bit words.
  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  // Count of one bits in a byte.
  function automatic logic [3:0] popcount8(input logic [7:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int b = 0; b < 8; b++) begin
      n = n + {3'd0, v[b]};
    end
    return n;
  endfunction

  // Prefix length of a mask: the count of its one bits.
  function automatic logic [5:0] popcount32(input logic [31:0] v);
    logic [4:0] lo;
    logic [4:0] hi;
    lo = {1'b0, popcount8(v[7:0])} + {1'b0, popcount8(v[15:8])};
    hi = {1'b0, popcount8(v[23:16])} + {1'b0, popcount8(v[31:24])};
    return {1'b0, lo} + {1'b0, hi};
  endfunction

endpackage

FILE: rtl/ipv4_forwarding_decision.sv
// Top level of the IPv4 header check and longest-prefix forwarding decision.
// Depends on ipv4fd_pkg and instantiates a chain of ipv4fd_route_cell.
`timescale 1ns / 1ps

// Channel       Direction  Handshake                  Carries
// s_axis        in         s_axis_tvalid/tready       route write or one header word
// m_axis        out        m_axis_tvalid/tready       one verdict per header
// cfg           in         cfg_we_i (no wait)         router interface addresses
//
// The input takes one header word or route write per cycle while it is ready.
// After the tenth word the block evaluates the header; when the verdict needs
// the route table, the lookup token walks the cell chain, one cell per cycle.
// Input is held off during evaluation and the walk, and the tenth word is held
// off while the previous verdict still waits in the output register.
// Reset clears the word count, the route valid bits and the address registers.

module ipv4_forwarding_decision #(
  parameter int ROUTE_ENTRIES = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Fields from bit 0: route_index[3:0], route_dest[35:4], route_mask[67:36],
  // route_port[69:68], route_valid[70], header_word[86:71],
  // frame_length[102:87], icmp_byte[110:103], zero pad[111].
  input  logic [ipv4fd_pkg::S_TDATA_W-1:0]    s_axis_tdata_i,
  // Fields from bit 0: op[0].
  input  logic                                s_axis_tuser_i,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // Fields from bit 0: action[2:0], out_port[4:3], dst_address[36:5],
  // new_ttl[44:37], new_checksum[60:45], zero pad[63:61].
  output logic [ipv4fd_pkg::M_TDATA_W-1:0]    m_axis_tdata_o,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  input  logic                                cfg_we_i,
  input  logic [ipv4fd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [ipv4fd_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import ipv4fd_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EVAL = 2'd1;
  localparam logic [1:0] ST_WALK = 2'd2;
  localparam logic [3:0] LAST_WORD = 4'(HDR_WORDS - 1);

  // Input field views.
  logic [3:0]  in_route_index;
  logic [31:0] in_route_dest;
  logic [31:0] in_route_mask;
  logic [1:0]  in_route_port;
  logic        in_route_valid;
  logic [15:0] in_header_word;
  logic [15:0] in_frame_length;
  logic [7:0]  in_icmp_byte;

  assign in_route_index  = s_axis_tdata_i[3:0];
  assign in_route_dest   = s_axis_tdata_i[35:4];
  assign in_route_mask   = s_axis_tdata_i[67:36];
  assign in_route_port   = s_axis_tdata_i[69:68];
  assign in_route_valid  = s_axis_tdata_i[70];
  assign in_header_word  = s_axis_tdata_i[86:71];
  assign in_frame_length = s_axis_tdata_i[102:87];
  assign in_icmp_byte    = s_axis_tdata_i[110:103];

  logic [1:0]  state_q, state_d;
  logic [3:0]  word_count_q;
  logic [15:0] other_sum_q;
  logic [15:0] stored_csum_q;
  logic [15:0] ttl_proto_q;
  logic        form_ok_q;
  logic [15:0] dst_hi_q;
  logic [31:0] dst_q;
  logic [15:0] frame_len_q;
  logic [7:0]  icmp_byte_q;
  logic [7:0]  nttl_q;
  logic [15:0] ncsum_q;
  logic [31:0] local_addr_q [4];

  logic        out_valid_q;
  action_e     out_action_q;
  logic [1:0]  out_port_q;
  logic [31:0] out_dst_q;
  logic [7:0]  out_ttl_q;
  logic [15:0] out_csum_q;

  logic        in_fire;
  logic        hdr_fire;
  logic        last_fire;
  route_wr_t   route_wr;
  walk_t       chain [ROUTE_ENTRIES+1];

  // Input is taken only while idle; the closing word also needs a free output register.
  assign s_axis_tready_o = (state_q == ST_IDLE) &&
                           (!out_valid_q || (word_count_q != LAST_WORD));
  assign in_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign hdr_fire  = in_fire && (s_axis_tuser_i == OP_HEADER_WORD);
  assign last_fire = hdr_fire && (word_count_q == LAST_WORD);

  // Interface address registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        local_addr_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      local_addr_q[cfg_index_i] <= cfg_data_i;
    end
  end

  // Word counter; route writes leave it alone.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_count_q <= '0;
    end else if (hdr_fire) begin
      word_count_q <= last_fire ? 4'd0 : word_count_q + 4'd1;
    end
  end

  // Header field capture and running checksum of all words except TTL/protocol
  // and the stored checksum.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      other_sum_q   <= '0;
      stored_csum_q <= '0;
      ttl_proto_q   <= '0;
      form_ok_q     <= 1'b0;
    end else if (hdr_fire) begin
      unique case (word_count_q)
        4'd0: begin
          other_sum_q <= in_header_word;
          form_ok_q   <= (in_header_word[15:12] == IP_VERSION_4) &&
                         (in_header_word[11:8] == IP_IHL_5);
        end
        4'd4: ttl_proto_q   <= in_header_word;
        4'd5: stored_csum_q <= in_header_word;
        default: other_sum_q <= ones_add(other_sum_q, in_header_word);
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (hdr_fire && (word_count_q == 4'd8)) begin
      dst_hi_q <= in_header_word;
    end
    if (last_fire) begin
      dst_q       <= {dst_hi_q, in_header_word};
      frame_len_q <= in_frame_length;
      icmp_byte_q <= in_icmp_byte;
    end
  end

  // Verdict logic for the evaluation cycle.
  logic [15:0] sum_all;
  logic        csum_bad;
  logic        is_local;
  logic [7:0]  ttl;
  logic        need_route;
  action_e     eval_action;

  assign sum_all  = ones_add(other_sum_q, ttl_proto_q);
  assign csum_bad = (~sum_all) != stored_csum_q;
  assign ttl      = ttl_proto_q[15:8];

  always_comb begin
    is_local = 1'b0;
    for (int i = 0; i < 4; i++) begin
      is_local = is_local || ((local_addr_q[i] != '0) && (local_addr_q[i] == dst_q));
    end
  end

  always_comb begin
    need_route = 1'b0;
    priority if (!form_ok_q || (frame_len_q < MIN_FRAME_LEN)) begin
      eval_action = ACT_MALFORMED;
    end else if (csum_bad) begin
      eval_action = ACT_BAD_CSUM;
    end else if (is_local) begin
      priority if (ttl_proto_q[7:0] != PROTO_ICMP) begin
        eval_action = ACT_PORT_UNREACH;
      end else if (frame_len_q < MIN_ICMP_FRAME_LEN) begin
        eval_action = ACT_LOCAL_DROP;
      end else if (icmp_byte_q == ICMP_ECHO_REQUEST) begin
        eval_action = ACT_ECHO_REPLY;
      end else begin
        eval_action = ACT_LOCAL_DROP;
      end
    end else if (ttl <= 8'd1) begin
      eval_action = ACT_TTL_EXCEEDED;
    end else begin
      eval_action = ACT_NET_UNREACH;
      need_route  = 1'b1;
    end
  end

  // Forward fields are prepared during evaluation for use at the end of the walk.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_EVAL) begin
      nttl_q  <= ttl - 8'd1;
      ncsum_q <= ~ones_add(other_sum_q, ttl_proto_q - TTL_ONE);
    end
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (last_fire) state_d = ST_EVAL;
      ST_EVAL: state_d = need_route ? ST_WALK : ST_IDLE;
      ST_WALK: if (chain[ROUTE_ENTRIES].tok) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Route chain: writes are broadcast, the lookup token enters cell 0.
  assign route_wr = '{en:    in_fire && (s_axis_tuser_i == OP_ROUTE_WRITE),
                      index: in_route_index,
                      dest:  in_route_dest,
                      mask:  in_route_mask,
                      port:  in_route_port,
                      valid: in_route_valid};

  assign chain[0] = '{tok:   (state_q == ST_EVAL) && need_route,
                      dst:   dst_q,
                      found: 1'b0,
                      plen:  6'd0,
                      port:  2'd0};

  for (genvar g = 0; g < ROUTE_ENTRIES; g++) begin : g_cell
    ipv4fd_route_cell #(
      .CellIdx (g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .wr_i   (route_wr),
      .walk_i (chain[g]),
      .walk_o (chain[g+1])
    );
  end

  // Output register.
  logic load_eval;
  logic load_walk;

  assign load_eval = (state_q == ST_EVAL) && !need_route;
  assign load_walk = (state_q == ST_WALK) && chain[ROUTE_ENTRIES].tok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_eval || load_walk) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_eval) begin
      out_action_q <= eval_action;
      out_port_q   <= 2'd0;
      out_dst_q    <= dst_q;
      out_ttl_q    <= 8'd0;
      out_csum_q   <= 16'd0;
    end else if (load_walk) begin
      out_dst_q <= dst_q;
      if (chain[ROUTE_ENTRIES].found) begin
        out_action_q <= ACT_FORWARD;
        out_port_q   <= chain[ROUTE_ENTRIES].port;
        out_ttl_q    <= nttl_q;
        out_csum_q   <= ncsum_q;
      end else begin
        out_action_q <= ACT_NET_UNREACH;
        out_port_q   <= 2'd0;
        out_ttl_q    <= 8'd0;
        out_csum_q   <= 16'd0;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'd0, out_csum_q, out_ttl_q, out_dst_q, out_port_q, out_action_q};

endmodule

FILE: rtl/ipv4fd_route_cell.sv
// One route table entry with its own match logic, a link in the lookup chain.
// Depends on ipv4fd_pkg for the write and token structs and popcount32.
`timescale 1ns / 1ps

module ipv4fd_route_cell #(
  parameter int CellIdx = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ipv4fd_pkg::route_wr_t wr_i,
  input  ipv4fd_pkg::walk_t     walk_i,
  output ipv4fd_pkg::walk_t     walk_o
);
  import ipv4fd_pkg::*;

  logic        valid_q;
  logic [31:0] prefix_q;
  logic [31:0] mask_q;
  logic [5:0]  plen_q;
  logic [1:0]  port_q;
  logic        wr_sel;
  logic        hit;
  logic        take;
  logic        tok_q;
  walk_t       walk_d;
  walk_t       walk_q;

  assign wr_sel = wr_i.en && ({28'd0, wr_i.index} == 32'(CellIdx));

  // The valid bit is cleared by reset; the entry payload is only defined once written.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (wr_sel) begin
      valid_q <= wr_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_sel) begin
      prefix_q <= wr_i.dest;
      mask_q   <= wr_i.mask;
      plen_q   <= popcount32(wr_i.mask);
      port_q   <= wr_i.port;
    end
  end

  // A matching entry replaces the best so far only with a strictly longer prefix,
  // so the lowest index wins on ties.
  assign hit  = valid_q && ((walk_i.dst & mask_q) == prefix_q);
  assign take = hit && (!walk_i.found || (plen_q > walk_i.plen));

  always_comb begin
    walk_d = walk_i;
    if (take) begin
      walk_d.found = 1'b1;
      walk_d.plen  = plen_q;
      walk_d.port  = port_q;
    end
  end

  // Hand the token to the next cell in the following cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= 1'b0;
    end else begin
      tok_q <= walk_i.tok;
    end
  end

  always_ff @(posedge clk_i) begin
    walk_q <= walk_d;
  end

  always_comb begin
    walk_o     = walk_q;
    walk_o.tok = tok_q;
  end

endmodule

FILE: rtl/ipv4fd_checker.sv
// Port-level checker for ipv4_forwarding_decision, bound to the top level.
// Depends on ipv4fd_pkg for payload widths and verdict codes.
`timescale 1ns / 1ps

module ipv4fd_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid_i,
  input logic                              s_axis_tready_o,
  input logic [ipv4fd_pkg::M_TDATA_W-1:0]  m_axis_tdata_o,
  input logic                              m_axis_tvalid_o,
  input logic                              m_axis_tready_i
);
  import ipv4fd_pkg::*;

  logic in_fire;
  logic is_fwd;
  logic extras_zero;

  assign in_fire     = s_axis_tvalid_i && s_axis_tready_o;
  assign is_fwd      = m_axis_tdata_o[2:0] == ACT_FORWARD;
  assign extras_zero = (m_axis_tdata_o[4:3] == 2'd0) && (m_axis_tdata_o[60:37] == '0);

  // A stalled verdict stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("verdict changed while stalled");

  // At least the evaluation cycle lies between an input transaction and a new verdict.
  a_no_early_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !$rose(m_axis_tvalid_o))
    else $error("verdict appeared right after an input transaction");

  // A forwarded packet always leaves with a TTL of at least one.
  a_fwd_ttl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && is_fwd |-> m_axis_tdata_o[44:37] != 8'd0)
    else $error("forward verdict with zero TTL");

  // Port, TTL and checksum are zero on every verdict but forward.
  a_nonfwd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !is_fwd |-> extras_zero)
    else $error("non-forward verdict carries forward fields");

endmodule

bind ipv4_forwarding_decision ipv4fd_checker u_ipv4fd_checker (.*);

FILE: tb/ipv4_forwarding_decision_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the IPv4 forwarding decision block: a scoreboard class predicts
// each verdict from the accepted stream and checks the block's output against it.
// Depends on ipv4fd_pkg and the RTL of ipv4_forwarding_decision.

module ipv4_forwarding_decision_test;
  import ipv4fd_pkg::*;

  localparam int NUM_ROUTES = 16;
  // A routed header passes the whole route chain; leave margin on top of that.
  localparam int SETTLE_CYCLES = 48;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 115;
  localparam logic [7:0] HDR_V4 = 8'h45;

  // Register indexes of the interface addresses.
  localparam logic [CFG_IDX_W-1:0] LADDR_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] LADDR_B = 2'd1;
  localparam logic [CFG_IDX_W-1:0] LADDR_C = 2'd2;
  localparam logic [CFG_IDX_W-1:0] LADDR_D = 2'd3;

  // One input transaction, unpacked.
  typedef struct {
    logic        op;
    logic [3:0]  rt_index;
    logic [31:0] rt_dest;
    logic [31:0] rt_mask;
    logic [1:0]  rt_port;
    logic        rt_valid;
    logic [15:0] hword;
    logic [15:0] flen;
    logic [7:0]  icmp;
  } fwd_item_t;

  // One verdict, unpacked.
  typedef struct {
    action_e     action;
    logic [1:0]  port;
    logic [31:0] dst;
    logic [7:0]  ttl;
    logic [15:0] csum;
  } verdict_t;

  // Predicts verdicts from accepted input transactions and checks the output.
  class verdict_scoreboard;
    logic [31:0] local_addr [4];
    logic [3:0]  word_cnt;
    logic [15:0] run_sum;
    logic [15:0] csum_field;
    logic [15:0] ttl_proto;
    logic        form_ok;
    logic [31:0] dst_acc;
    logic [31:0] rt_prefix [NUM_ROUTES];
    logic [31:0] rt_mask [NUM_ROUTES];
    logic [1:0]  rt_port [NUM_ROUTES];
    logic        rt_valid [NUM_ROUTES];
    verdict_t    pending_verdicts [$];
    int          errors;

    function new();
      word_cnt = '0;
      run_sum = '0;
      csum_field = '0;
      ttl_proto = '0;
      form_ok = 1'b0;
      dst_acc = '0;
      errors = 0;
      foreach (local_addr[k]) local_addr[k] = '0;
      for (int i = 0; i < NUM_ROUTES; i++) begin
        rt_prefix[i] = '0;
        rt_mask[i] = '0;
        rt_port[i] = '0;
        rt_valid[i] = 1'b0;
      end
    endfunction

    // End-around-carry sum of two 16-bit words.
    static function logic [15:0] fold_add(logic [15:0] a, logic [15:0] b);
      logic [31:0] s;
      s = {16'd0, a} + {16'd0, b};
      s = {16'd0, s[15:0]} + {16'd0, s[31:16]};
      return s[15:0];
    endfunction

    function void note_input(fwd_item_t it);
      verdict_t    v;
      logic        is_local;
      logic        found;
      int          best_len;
      logic [15:0] calc;

      if (it.op == OP_ROUTE_WRITE) begin
        rt_prefix[it.rt_index] = it.rt_dest;
        rt_mask[it.rt_index] = it.rt_mask;
        rt_port[it.rt_index] = it.rt_port;
        rt_valid[it.rt_index] = it.rt_valid;
        return;
      end

      // Accumulate the header word by its position.
      case (word_cnt)
        4'd0: begin
          run_sum = it.hword;
          form_ok = (it.hword[15:12] == IP_VERSION_4) && (it.hword[11:8] == IP_IHL_5);
        end
        4'd4: ttl_proto = it.hword;
        4'd5: csum_field = it.hword;
        4'd8: begin
          run_sum = fold_add(run_sum, it.hword);
          dst_acc = {it.hword, 16'd0};
        end
        default: begin
          run_sum = fold_add(run_sum, it.hword);
          if (word_cnt == 4'd9) dst_acc[15:0] = it.hword;
        end
      endcase

      if (word_cnt < 4'(HDR_WORDS - 1)) begin
        word_cnt++;
        return;
      end
      word_cnt = '0;

      v.action = ACT_FORWARD;
      v.port = '0;
      v.dst = dst_acc;
      v.ttl = '0;
      v.csum = '0;

      is_local = 1'b0;
      foreach (local_addr[k]) begin
        if (local_addr[k] != '0 && local_addr[k] == dst_acc) is_local = 1'b1;
      end
      calc = ~fold_add(run_sum, ttl_proto);

      // Checks in priority order, then the longest-prefix route walk.
      if (it.flen < MIN_FRAME_LEN || !form_ok) begin
        v.action = ACT_MALFORMED;
      end else if (calc != csum_field) begin
        v.action = ACT_BAD_CSUM;
      end else if (is_local) begin
        if (ttl_proto[7:0] != PROTO_ICMP) v.action = ACT_PORT_UNREACH;
        else if (it.flen < MIN_ICMP_FRAME_LEN) v.action = ACT_LOCAL_DROP;
        else if (it.icmp == ICMP_ECHO_REQUEST) v.action = ACT_ECHO_REPLY;
        else v.action = ACT_LOCAL_DROP;
      end else if (ttl_proto[15:8] <= 8'd1) begin
        v.action = ACT_TTL_EXCEEDED;
      end else begin
        found = 1'b0;
        best_len = 0;
        for (int i = 0; i < NUM_ROUTES; i++) begin
          if (rt_valid[i] && (dst_acc & rt_mask[i]) == rt_prefix[i] &&
              (!found || $countones(rt_mask[i]) > best_len)) begin
            found = 1'b1;
            best_len = $countones(rt_mask[i]);
            v.port = rt_port[i];
          end
        end
        if (!found) begin
          v.action = ACT_NET_UNREACH;
          v.port = '0;
        end else begin
          v.ttl = ttl_proto[15:8] - 8'd1;
          v.csum = ~fold_add(run_sum, ttl_proto - TTL_ONE);
        end
      end
      pending_verdicts.push_back(v);
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      $display("%0t: mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
    endtask

    task check_result(logic [M_TDATA_W-1:0] tdata);
      verdict_t want;
      if (pending_verdicts.size() == 0) begin
        report_mismatch("unexpected verdict", tdata, '0);
        return;
      end
      want = pending_verdicts.pop_front();
      if (tdata[2:0] !== want.action) report_mismatch("action", tdata[2:0], want.action);
      if (tdata[4:3] !== want.port) report_mismatch("out_port", tdata[4:3], want.port);
      if (tdata[36:5] !== want.dst) report_mismatch("dst_address", tdata[36:5], want.dst);
      if (tdata[44:37] !== want.ttl) report_mismatch("new_ttl", tdata[44:37], want.ttl);
      if (tdata[60:45] !== want.csum) report_mismatch("new_checksum", tdata[60:45], want.csum);
    endtask
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic [S_TDATA_W-1:0]  s_axis_tdata_i = '0;
  logic                  s_axis_tuser_i = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [M_TDATA_W-1:0]  m_axis_tdata_o;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  verdict_scoreboard sb = new();
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  logic sink_hold = 1'b0;
  int items_sent = 0;

  ipv4_forwarding_decision #(
    .ROUTE_ENTRIES(NUM_ROUTES)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // 2 ns clock.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Receiver: random stalls, or a long hold-off while sink_hold is set.
  always @(negedge clk_i) begin
    if (!rst_ni || sink_hold) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Check every verdict transaction as it is accepted.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o === 1'b1 && m_axis_tready_i) begin
      sb.check_result(m_axis_tdata_o);
    end
  end

  // The run ends in failure if it has not finished by the cycle limit.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // Holds the receiver off for a number of cycles.
  task automatic hold_sink(int cycles);
    sink_hold = 1'b1;
    repeat (cycles) @(posedge clk_i);
    sink_hold = 1'b0;
  endtask

  function automatic fwd_item_t random_item();
    fwd_item_t it;
    it.op = 1'($urandom);
    it.rt_index = 4'($urandom);
    it.rt_dest = $urandom;
    it.rt_mask = $urandom;
    it.rt_port = 2'($urandom);
    it.rt_valid = 1'($urandom);
    it.hword = 16'($urandom);
    it.flen = 16'($urandom);
    it.icmp = 8'($urandom);
    return it;
  endfunction

  // Offers one input transaction after a random gap and waits for acceptance.
  task automatic send_item(fwd_item_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      @(negedge clk_i);
      s_axis_tvalid_i <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= it.op;
    s_axis_tdata_i <= {1'b0, it.icmp, it.flen, it.hword, it.rt_valid, it.rt_port,
                       it.rt_mask, it.rt_dest, it.rt_index};
    do @(posedge clk_i); while (s_axis_tready_o !== 1'b1);
    sb.note_input(it);
    items_sent++;
  endtask

  task automatic send_word(logic [15:0] w, logic tenth, logic [15:0] flen, logic [7:0] icmp);
    fwd_item_t it;
    it = random_item();
    it.op = OP_HEADER_WORD;
    it.hword = w;
    if (tenth) begin
      it.flen = flen;
      it.icmp = icmp;
    end
    send_item(it);
  endtask

  task automatic send_junk_word();
    fwd_item_t it;
    it = random_item();
    it.op = OP_HEADER_WORD;
    send_item(it);
  endtask

  task automatic send_route_write(logic [3:0] idx, logic [31:0] dest, logic [31:0] mask,
                                  logic [1:0] port, logic valid);
    fwd_item_t it;
    it = random_item();
    it.op = OP_ROUTE_WRITE;
    it.rt_index = idx;
    it.rt_dest = dest;
    it.rt_mask = mask;
    it.rt_port = port;
    it.rt_valid = valid;
    send_item(it);
  endtask

  // Mostly contiguous masks with a matching prefix; some odd masks and dead entries.
  task automatic send_random_route();
    logic [31:0] mask;
    logic [31:0] dest;
    int          r;
    mask = ~(32'hFFFF_FFFF >> $urandom_range(32));
    r = $urandom_range(9);
    if (r == 0) mask = $urandom;
    dest = $urandom & mask;
    if (r == 1) dest = $urandom;
    send_route_write(4'($urandom), dest, mask, 2'($urandom), $urandom_range(9) != 0);
  endtask

  // Builds a ten-word header with a correct checksum unless corrupt is set.
  task automatic send_header(logic [7:0] ver_ihl, logic [7:0] ttl, logic [7:0] proto,
                             logic [31:0] dst, logic corrupt, logic [15:0] flen,
                             logic [7:0] icmp, logic mid_route);
    logic [15:0] words [HDR_WORDS];
    logic [15:0] sum;
    int          route_pos;
    words[0] = {ver_ihl, 8'($urandom)};
    for (int i = 1; i < HDR_WORDS; i++) words[i] = 16'($urandom);
    words[4] = {ttl, proto};
    words[8] = dst[31:16];
    words[9] = dst[15:0];
    sum = '0;
    for (int i = 0; i < HDR_WORDS; i++) begin
      if (i != 5) sum = verdict_scoreboard::fold_add(sum, words[i]);
    end
    words[5] = ~sum;
    if (corrupt) words[5] = words[5] ^ (16'd1 << $urandom_range(15));
    route_pos = mid_route ? $urandom_range(1, HDR_WORDS - 1) : -1;
    for (int i = 0; i < HDR_WORDS; i++) begin
      if (i == route_pos) send_random_route();
      send_word(words[i], i == HDR_WORDS - 1, flen, icmp);
    end
  endtask

  // Destination: often local, often inside a stored route, sometimes anything.
  function automatic logic [31:0] pick_dst();
    int j;
    int r;
    r = $urandom_range(99);
    j = $urandom_range(NUM_ROUTES - 1);
    if (r < 25) return sb.local_addr[$urandom_range(3)];
    if (r < 80) return (sb.rt_prefix[j] & sb.rt_mask[j]) | ($urandom & ~sb.rt_mask[j]);
    return $urandom;
  endfunction

  function automatic logic [15:0] pick_flen();
    int r;
    r = $urandom_range(99);
    if (r < 5) return 16'($urandom_range(33));
    if (r < 10) return 16'($urandom_range(37, 34));
    if (r < 15) return 16'($urandom);
    return 16'($urandom_range(1514, 38));
  endfunction

  function automatic logic [7:0] pick_ttl();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 8'($urandom_range(1));
    if (r < 15) return 8'hFF;
    return 8'($urandom_range(255, 2));
  endfunction

  // Writes all four interface addresses; only done while the block is idle.
  task automatic set_local_addrs(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                 logic [31:0] d);
    logic [CFG_IDX_W-1:0] idx [4];
    logic [31:0]          val [4];
    idx = '{LADDR_A, LADDR_B, LADDR_C, LADDR_D};
    val = '{a, b, c, d};
    for (int k = 0; k < 4; k++) begin
      @(negedge clk_i);
      cfg_we_i <= 1'b1;
      cfg_index_i <= idx[k];
      cfg_data_i <= val[k];
      @(negedge clk_i);
      cfg_we_i <= 1'b0;
      sb.local_addr[idx[k]] = val[k];
    end
  endtask

  // Stops offering input and waits until every verdict has arrived and the walk has ended.
  task automatic wait_for_quiet();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Random traffic: mostly well-formed headers, with route writes and stray words mixed in.
  task automatic run_phase(int n_items);
    int start;
    int r;
    logic [7:0] ver_ihl;
    start = items_sent;
    while (items_sent - start < n_items) begin
      r = $urandom_range(99);
      if (r < 10) begin
        send_random_route();
      end else if (r < 16) begin
        repeat ($urandom_range(12, 1)) send_junk_word();
      end else begin
        // Realign to a header boundary first.
        while (sb.word_cnt != '0) send_junk_word();
        ver_ihl = ($urandom_range(99) < 90) ? HDR_V4 : 8'($urandom);
        send_header(ver_ihl, pick_ttl(),
                    ($urandom_range(99) < 45) ? PROTO_ICMP : 8'($urandom),
                    pick_dst(), $urandom_range(99) < 8, pick_flen(),
                    ($urandom_range(1) == 0) ? ICMP_ECHO_REQUEST : 8'($urandom),
                    $urandom_range(19) == 0);
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed cases with the second interface left unused.
    set_local_addrs(32'hC0A8_0001, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0A00_0001);
    // Empty route table, and a zero destination that must not match the unused interface.
    send_header(HDR_V4, 8'd64, 8'd17, 32'h0000_0000, 1'b0, 16'd60, 8'h00, 1'b0);
    send_route_write(4'd0, 32'h0000_0000, 32'h0000_0000, 2'd1, 1'b1);
    send_route_write(4'd1, 32'h0A00_0000, 32'hFF00_0000, 2'd2, 1'b1);
    send_route_write(4'd2, 32'h0A01_0000, 32'hFFFF_0000, 2'd3, 1'b1);
    send_route_write(4'd3, 32'h0A01_0000, 32'hFFFF_0000, 2'd0, 1'b1);
    send_route_write(4'd4, 32'h0003_0000, 32'h0F0F_0000, 2'd0, 1'b1);
    send_route_write(4'd14, 32'h0A09_0000, 32'hFFFF_0000, 2'd1, 1'b0);
    send_route_write(4'd15, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 2'd3, 1'b1);
    // Tie between equal prefixes goes to the lower index; TTL 2 forwards with TTL 1.
    send_header(HDR_V4, 8'd2, 8'd6, 32'h0A01_0203, 1'b0, 16'd60, 8'h00, 1'b0);
    // Inactive entry is skipped; largest TTL.
    send_header(HDR_V4, 8'hFF, 8'd17, 32'h0A09_0909, 1'b0, 16'd1514, 8'h00, 1'b0);
    // Non-contiguous mask counts its one bits.
    send_header(HDR_V4, 8'd64, PROTO_ICMP, 32'h1003_0405, 1'b0, 16'd98, 8'h08, 1'b0);
    send_header(HDR_V4, 8'd64, 8'd17, 32'hFFFF_FFFE, 1'b0, 16'd60, 8'h00, 1'b0);
    send_header(HDR_V4, 8'd64, 8'd17, 32'h0102_0304, 1'b0, 16'd60, 8'h00, 1'b0);
    // Local handling: echo at the shortest ICMP frame, too short, other type, not ICMP.
    send_header(HDR_V4, 8'd64, PROTO_ICMP, 32'hFFFF_FFFF, 1'b0, MIN_ICMP_FRAME_LEN,
                ICMP_ECHO_REQUEST, 1'b0);
    send_header(HDR_V4, 8'd64, PROTO_ICMP, 32'h0A00_0001, 1'b0, MIN_ICMP_FRAME_LEN - 16'd1,
                ICMP_ECHO_REQUEST, 1'b0);
    send_header(HDR_V4, 8'd64, PROTO_ICMP, 32'hC0A8_0001, 1'b0, 16'hFFFF, 8'hFF, 1'b0);
    send_header(HDR_V4, 8'd0, 8'd6, 32'hC0A8_0001, 1'b0, 16'd60, 8'h00, 1'b0);
    // TTL at one and zero on a routed destination.
    send_header(HDR_V4, 8'd1, 8'd6, 32'h0A09_0909, 1'b0, 16'd60, 8'h00, 1'b0);
    send_header(HDR_V4, 8'd0, 8'd6, 32'h0A09_0909, 1'b0, 16'd60, 8'h00, 1'b0);
    // Malformed: short frame (even with a bad checksum), wrong version, wrong length.
    send_header(HDR_V4, 8'd64, 8'd6, 32'h0A09_0909, 1'b1, MIN_FRAME_LEN - 16'd1,
                8'h00, 1'b0);
    send_header(8'h65, 8'd64, 8'd6, 32'h0A09_0909, 1'b0, 16'd60, 8'h00, 1'b0);
    send_header(8'h46, 8'd64, 8'd6, 32'h0A09_0909, 1'b0, MIN_FRAME_LEN, 8'h00, 1'b0);
    // Bad checksum ahead of local handling.
    send_header(HDR_V4, 8'd64, PROTO_ICMP, 32'hC0A8_0001, 1'b1, 16'd60,
                ICMP_ECHO_REQUEST, 1'b0);
    // A route write in the middle of a header leaves the word count alone.
    send_header(HDR_V4, 8'd64, 8'd6, 32'h0A01_0203, 1'b0, 16'd60, 8'h00, 1'b1);
    // Dropping the default route leaves an unrouted destination.
    send_route_write(4'd0, 32'h0000_0000, 32'h0000_0000, 2'd1, 1'b0);
    send_header(HDR_V4, 8'd64, 8'd6, 32'h0102_0304, 1'b0, 16'd60, 8'h00, 1'b0);
    wait_for_quiet();

    // No idling, with one long receiver hold-off so the block backs up.
    set_local_addrs($urandom, $urandom, $urandom, $urandom);
    src_idle_pct = 0;
    sink_stall_pct = 0;
    fork
      hold_sink(400);
    join_none
    run_phase(PHASE_ITEMS);
    wait_for_quiet();

    // Idle sender; no interface in use.
    set_local_addrs(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    src_idle_pct = 53;
    sink_stall_pct = 0;
    run_phase(PHASE_ITEMS);
    wait_for_quiet();

    // Stalling receiver; every interface at the top address.
    set_local_addrs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    src_idle_pct = 0;
    sink_stall_pct = 53;
    run_phase(PHASE_ITEMS);
    wait_for_quiet();

    // Both sides idle now and then.
    set_local_addrs(32'h0000_0001, $urandom, 32'h0000_0000, $urandom);
    src_idle_pct = 14;
    sink_stall_pct = 14;
    run_phase(PHASE_ITEMS);
    wait_for_quiet();

    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
